FILE: hdl/loss_ewma_quality_ladder_assert.svh
// Assertion macros for the loss EWMA quality ladder.
// Expects clk and arst_n in the scope of use.
`ifndef LOSS_EWMA_QUALITY_LADDER_ASSERT_SVH
`define LOSS_EWMA_QUALITY_LADDER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LEWQL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define LEWQL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/lewql_pkg.sv
// Shared types and constants for the loss EWMA quality ladder.
// No dependencies.
package lewql_pkg;

	localparam int unsigned MAX_THRESHOLDS = 4;

	localparam int unsigned FRAC_W  = 17;
	localparam int unsigned LEVEL_W = 3;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned PROD_W  = 2 * FRAC_W;

	localparam logic [FRAC_W-1:0] Q16_ONE = 17'h10000;

	localparam logic [IDX_W-1:0] REG_THR_COUNT = 3'd0;
	localparam logic [IDX_W-1:0] REG_WEIGHT    = 3'd1;
	localparam logic [IDX_W-1:0] REG_HYST      = 3'd2;
	localparam logic [IDX_W-1:0] REG_THR_0     = 3'd3;
	localparam logic [IDX_W-1:0] REG_THR_1     = 3'd4;
	localparam logic [IDX_W-1:0] REG_THR_2     = 3'd5;
	localparam logic [IDX_W-1:0] REG_THR_3     = 3'd6;

	localparam logic [FRAC_W-1:0] WEIGHT_RST = 17'h08000;

	typedef struct packed {
		logic [LEVEL_W-1:0] count;
		logic [FRAC_W-1:0]  weight;
		logic [FRAC_W-1:0]  hyst;
	} cfg_t;

	function automatic logic [FRAC_W-1:0] sat_one(input logic [FRAC_W-1:0] v);
		sat_one = (v > Q16_ONE) ? Q16_ONE : v;
	endfunction

endpackage

FILE: hdl/lewql_cfg.sv
// Configuration register file for the loss EWMA quality ladder.
// Depends on lewql_pkg. Outputs are saturated and clamped.
module lewql_cfg #(
	parameter int unsigned MaxThr = lewql_pkg::MAX_THRESHOLDS,
	parameter int unsigned TIdxW  = (MaxThr > 1) ? $clog2(MaxThr) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [lewql_pkg::IDX_W-1:0]        cfg_index,
	input  logic [lewql_pkg::FRAC_W-1:0]       cfg_data,
	output lewql_pkg::cfg_t                    cfg,
	output logic [lewql_pkg::FRAC_W-1:0]       thr [MaxThr]
);

	localparam logic [lewql_pkg::LEVEL_W-1:0] MaxCnt = lewql_pkg::LEVEL_W'(MaxThr);

	logic [lewql_pkg::LEVEL_W-1:0] count_q;
	logic [lewql_pkg::FRAC_W-1:0]  weight_q;
	logic [lewql_pkg::FRAC_W-1:0]  hyst_q;
	logic [lewql_pkg::FRAC_W-1:0]  thr_q [MaxThr];
	logic [lewql_pkg::IDX_W-1:0]   thr_sel;

	assign thr_sel = cfg_index - lewql_pkg::REG_THR_0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			weight_q <= lewql_pkg::WEIGHT_RST;
			hyst_q   <= '0;
			for (int i = 0; i < MaxThr; i++) begin
				thr_q[i] <= lewql_pkg::Q16_ONE;
			end
		end else if (cfg_wr_en) begin
			unique case (cfg_index) inside
				lewql_pkg::REG_THR_COUNT: count_q  <= cfg_data[lewql_pkg::LEVEL_W-1:0];
				lewql_pkg::REG_WEIGHT:    weight_q <= cfg_data;
				lewql_pkg::REG_HYST:      hyst_q   <= cfg_data;
				lewql_pkg::REG_THR_0, lewql_pkg::REG_THR_1,
				lewql_pkg::REG_THR_2, lewql_pkg::REG_THR_3: begin
					if (32'(thr_sel) < MaxThr) begin
						thr_q[thr_sel[TIdxW-1:0]] <= cfg_data;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.count  = (count_q > MaxCnt) ? MaxCnt : count_q;
		cfg.weight = lewql_pkg::sat_one(weight_q);
		cfg.hyst   = lewql_pkg::sat_one(hyst_q);
		for (int i = 0; i < MaxThr; i++) begin
			thr[i] = lewql_pkg::sat_one(thr_q[i]);
		end
	end

endmodule

FILE: hdl/lewql_mul.sv
// Shared 17x17 unsigned multiplier with registered product.
// Depends on lewql_pkg.
module lewql_mul (
	input  logic                          clk,
	input  logic [lewql_pkg::FRAC_W-1:0]  op_a,
	input  logic [lewql_pkg::FRAC_W-1:0]  op_b,
	output logic [lewql_pkg::PROD_W-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= lewql_pkg::PROD_W'(op_a) * lewql_pkg::PROD_W'(op_b);
	end

endmodule

FILE: hdl/loss_ewma_quality_ladder.sv
// Loss EWMA quality ladder, top level.
// Depends on lewql_pkg, lewql_cfg, lewql_mul and loss_ewma_quality_ladder_assert.svh.
//
// One loss sample per transaction; one result (level, smoothed loss) per sample.
// A sample is accepted in IDLE; the EWMA then takes the MULX, MULA and ADD
// states (skipped on the first sample, which seeds the average). UP climbs the
// ladder one step at a time, and each downward step takes DNM and DNC on the
// shared 17x17 multiplier; DONE then loads the output register, waiting while
// a result still held there is stalled. With threshold_count zero the sample
// goes straight to DONE. The input stalls while a sample is in work; a finished
// result sits in the output register while the next sample is accepted.
`include "loss_ewma_quality_ladder_assert.svh"

module loss_ewma_quality_ladder #(
	parameter int unsigned MaxThr = lewql_pkg::MAX_THRESHOLDS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [lewql_pkg::IDX_W-1:0]        cfg_index,
	input  logic [lewql_pkg::FRAC_W-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [lewql_pkg::FRAC_W-1:0]       loss_fraction,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [lewql_pkg::LEVEL_W-1:0]      requested_level,
	output logic [lewql_pkg::FRAC_W-1:0]       smoothed_loss
);

	localparam int unsigned TIdxW = (MaxThr > 1) ? $clog2(MaxThr) : 1;
	localparam int unsigned SumW  = lewql_pkg::PROD_W + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MULX = 3'd1;
	localparam logic [2:0] ST_MULA = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_UP   = 3'd4;
	localparam logic [2:0] ST_DNM  = 3'd5;
	localparam logic [2:0] ST_DNC  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	lewql_pkg::cfg_t                   cfg;
	logic [lewql_pkg::FRAC_W-1:0]      thr [MaxThr];

	logic [2:0]                        state_q;
	logic [lewql_pkg::FRAC_W-1:0]      x_q;
	logic [lewql_pkg::FRAC_W-1:0]      avg_q;
	logic                              seeded_q;
	logic [lewql_pkg::LEVEL_W-1:0]     cur_level_q;
	logic [lewql_pkg::LEVEL_W-1:0]     lvl_q;
	logic                              bypass_q;
	logic [lewql_pkg::PROD_W-1:0]      acc_q;
	logic                              out_valid_q;
	logic [lewql_pkg::LEVEL_W-1:0]     out_level_q;
	logic [lewql_pkg::FRAC_W-1:0]      out_loss_q;

	logic [lewql_pkg::FRAC_W-1:0]      op_a;
	logic [lewql_pkg::FRAC_W-1:0]      op_b;
	logic [lewql_pkg::PROD_W-1:0]      prod_q;
	logic [SumW-1:0]                   sum;
	logic [SumW-17:0]                  sum_shr;
	logic [lewql_pkg::FRAC_W-1:0]      avg_new;
	logic [lewql_pkg::LEVEL_W-1:0]     lvl_dn;
	logic [lewql_pkg::FRAC_W-1:0]      x_sat;
	logic                              in_acc;
	logic                              out_load;

	lewql_cfg #(
		.MaxThr (MaxThr),
		.TIdxW  (TIdxW)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.thr       (thr)
	);

	lewql_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign x_sat    = lewql_pkg::sat_one(loss_fraction);
	assign lvl_dn   = lvl_q - 3'd1;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign sum     = SumW'(acc_q) + SumW'(prod_q);
	assign sum_shr = sum[SumW-1:16];
	assign avg_new = (sum_shr > (SumW-16)'(lewql_pkg::Q16_ONE)) ? lewql_pkg::Q16_ONE
		: sum_shr[lewql_pkg::FRAC_W-1:0];

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			ST_MULX: begin
				op_a = cfg.weight;
				op_b = x_q;
			end
			ST_MULA: begin
				op_a = lewql_pkg::Q16_ONE - cfg.weight;
				op_b = avg_q;
			end
			ST_DNM: begin
				op_a = thr[lvl_dn[TIdxW-1:0]];
				op_b = lewql_pkg::Q16_ONE - cfg.hyst;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			avg_q       <= '0;
			seeded_q    <= 1'b0;
			cur_level_q <= '0;
			lvl_q       <= '0;
			bypass_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (cfg.count == '0) begin
							bypass_q <= 1'b1;
							lvl_q    <= '0;
							state_q  <= ST_DONE;
						end else begin
							bypass_q <= 1'b0;
							lvl_q    <= (cur_level_q > cfg.count) ? cfg.count : cur_level_q;
							if (!seeded_q) begin
								avg_q    <= x_sat;
								seeded_q <= 1'b1;
								state_q  <= ST_UP;
							end else begin
								state_q <= ST_MULX;
							end
						end
					end
				end
				ST_MULX: state_q <= ST_MULA;
				ST_MULA: state_q <= ST_ADD;
				ST_ADD: begin
					avg_q   <= avg_new;
					state_q <= ST_UP;
				end
				ST_UP: begin
					if (lvl_q < cfg.count && avg_q > thr[lvl_q[TIdxW-1:0]]) begin
						lvl_q <= lvl_q + 3'd1;
					end else if (lvl_q != '0) begin
						state_q <= ST_DNM;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DNM: state_q <= ST_DNC;
				ST_DNC: begin
					if ({1'b0, avg_q} < prod_q[lewql_pkg::PROD_W-1:16]) begin
						lvl_q   <= lvl_dn;
						state_q <= (lvl_dn != '0) ? ST_DNM : ST_DONE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						if (!bypass_q) begin
							cur_level_q <= lvl_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= x_sat;
		end
		if (state_q == ST_MULA) begin
			acc_q <= prod_q;
		end
		if (out_load) begin
			out_level_q <= lvl_q;
			out_loss_q  <= avg_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign requested_level = out_level_q;
	assign smoothed_loss   = out_loss_q;

	`LEWQL_ASSERT_SAME(a_level_range, out_valid, 32'(requested_level) <= MaxThr, "level beyond ladder")
	`LEWQL_ASSERT_SAME(a_loss_range, out_valid, smoothed_loss <= lewql_pkg::Q16_ONE, "average above one")
	`LEWQL_ASSERT_SAME(a_cur_level, 1'b1, 32'(cur_level_q) <= MaxThr, "stored level beyond ladder")
	`LEWQL_ASSERT_NEXT(a_bypass, in_acc && cfg.count == '0, state_q == ST_DONE && lvl_q == '0, "bypass missed")
	`LEWQL_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(smoothed_loss), "result lost")

endmodule

FILE: verif/testbench.sv
// Testbench for loss_ewma_quality_ladder: directed and random loss samples with
// register changes between phases, each result checked against an internal model.
// Depends on lewql_pkg and the loss_ewma_quality_ladder RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [lewql_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int unsigned QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [lewql_pkg::LEVEL_W-1:0] level;
		logic [lewql_pkg::FRAC_W-1:0]  loss;
	} ladder_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [lewql_pkg::IDX_W-1:0]   cfg_index;
	logic [lewql_pkg::FRAC_W-1:0]  cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [lewql_pkg::FRAC_W-1:0]  loss_fraction;
	logic                          out_valid;
	logic                          out_stall;
	logic [lewql_pkg::LEVEL_W-1:0] requested_level;
	logic [lewql_pkg::FRAC_W-1:0]  smoothed_loss;

	// register copies
	logic [lewql_pkg::LEVEL_W-1:0] thr_count_reg;
	logic [lewql_pkg::FRAC_W-1:0]  blend_weight;
	logic [lewql_pkg::FRAC_W-1:0]  hyst_band;
	logic [lewql_pkg::FRAC_W-1:0]  ladder_thr [4];
	// ladder state copies
	logic [lewql_pkg::FRAC_W-1:0]  ewma_q16;
	logic                          ewma_seeded;
	logic [lewql_pkg::LEVEL_W-1:0] ladder_level;

	ladder_result_t expected_ladder [$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	int unsigned src_idle_pct = 12;
	int unsigned sink_stall_pct = 76;

	loss_ewma_quality_ladder uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.loss_fraction  (loss_fraction),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.requested_level(requested_level),
		.smoothed_loss  (smoothed_loss)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [lewql_pkg::FRAC_W-1:0] clip_q16(input logic [63:0] v);
		return (v > 64'(lewql_pkg::Q16_ONE)) ? lewql_pkg::Q16_ONE
			: v[lewql_pkg::FRAC_W-1:0];
	endfunction

	function automatic ladder_result_t predict_ladder(
		input logic [lewql_pkg::FRAC_W-1:0] sample);
		int unsigned cnt;
		int unsigned lvl;
		logic [lewql_pkg::FRAC_W-1:0] x;
		logic [lewql_pkg::FRAC_W-1:0] w;
		logic [lewql_pkg::FRAC_W-1:0] h;
		logic [63:0] acc;
		logic [63:0] lowered;
		ladder_result_t r;
		cnt = (thr_count_reg > lewql_pkg::MAX_THRESHOLDS) ? lewql_pkg::MAX_THRESHOLDS
			: int'(thr_count_reg);
		if (cnt == 0) begin
			r.level = '0;
			r.loss = ewma_q16;
			return r;
		end
		x = clip_q16(64'(sample));
		w = clip_q16(64'(blend_weight));
		h = clip_q16(64'(hyst_band));
		if (!ewma_seeded) begin
			ewma_q16 = x;
			ewma_seeded = 1'b1;
		end else begin
			acc = 64'(w) * 64'(x)
				+ (64'(lewql_pkg::Q16_ONE) - 64'(w)) * 64'(ewma_q16);
			ewma_q16 = clip_q16(acc >> 16);
		end
		lvl = (ladder_level > cnt) ? cnt : int'(ladder_level);
		while (lvl < cnt && ewma_q16 > clip_q16(64'(ladder_thr[lvl])))
			lvl++;
		while (lvl > 0) begin
			lowered = (64'(clip_q16(64'(ladder_thr[lvl-1])))
				* (64'(lewql_pkg::Q16_ONE) - 64'(h))) >> 16;
			if (64'(ewma_q16) < lowered)
				lvl--;
			else
				break;
		end
		ladder_level = lewql_pkg::LEVEL_W'(lvl);
		r.level = ladder_level;
		r.loss = ewma_q16;
		return r;
	endfunction

	// mostly samples around the thresholds and their hysteresis-lowered values
	function automatic logic [lewql_pkg::FRAC_W-1:0] pick_loss();
		int unsigned sel;
		int unsigned k;
		longint v;
		sel = $urandom_range(0, 99);
		k = $urandom_range(0, 3);
		if (sel < 70) begin
			v = longint'(clip_q16(64'(ladder_thr[k])));
			if (sel >= 35)
				v = (v * (65536 - longint'(clip_q16(64'(hyst_band))))) >>> 16;
			v = v + longint'($urandom_range(0, 6000)) - 3000;
			if (v < 0)
				v = 0;
			if (v > 131071)
				v = 131071;
			return lewql_pkg::FRAC_W'(v);
		end
		if (sel < 90)
			return lewql_pkg::FRAC_W'($urandom_range(0, 65536));
		if (sel < 95)
			return ($urandom_range(0, 1) != 0) ? lewql_pkg::Q16_ONE : '0;
		return lewql_pkg::FRAC_W'($urandom_range(65537, 131071));
	endfunction

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_ladder.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [lewql_pkg::IDX_W-1:0] idx,
		input logic [lewql_pkg::FRAC_W-1:0] val);
		wait_for_results();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			lewql_pkg::REG_THR_COUNT: thr_count_reg = val[lewql_pkg::LEVEL_W-1:0];
			lewql_pkg::REG_WEIGHT: blend_weight = val;
			lewql_pkg::REG_HYST: hyst_band = val;
			lewql_pkg::REG_THR_0: ladder_thr[0] = val;
			lewql_pkg::REG_THR_1: ladder_thr[1] = val;
			lewql_pkg::REG_THR_2: ladder_thr[2] = val;
			lewql_pkg::REG_THR_3: ladder_thr[3] = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_loss(input logic [lewql_pkg::FRAC_W-1:0] sample);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		loss_fraction <= sample;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		expected_ladder.insert(expected_ladder.size(), predict_ladder(sample));
		@(posedge clk);
	endtask

	task automatic pick_settings();
		int unsigned sel;
		int unsigned cnt;
		int unsigned acc;
		logic [lewql_pkg::FRAC_W-1:0] val;
		if ($urandom_range(0, 5) == 0) begin
			for (int i = 0; i < 4; i++)
				write_reg(lewql_pkg::REG_THR_0 + lewql_pkg::IDX_W'(i),
					lewql_pkg::FRAC_W'($urandom_range(0, 131071)));
		end else begin
			acc = $urandom_range(1, 16000);
			for (int i = 0; i < 4; i++) begin
				write_reg(lewql_pkg::REG_THR_0 + lewql_pkg::IDX_W'(i), clip_q16(64'(acc)));
				acc += $urandom_range(1, 16000);
			end
		end
		sel = $urandom_range(0, 9);
		if (sel == 0)
			val = '0;
		else if (sel == 1)
			val = lewql_pkg::Q16_ONE;
		else if (sel == 2)
			val = lewql_pkg::FRAC_W'($urandom_range(65537, 131071));
		else
			val = lewql_pkg::FRAC_W'($urandom_range(4096, 65535));
		write_reg(lewql_pkg::REG_WEIGHT, val);
		sel = $urandom_range(0, 9);
		if (sel == 0)
			val = '0;
		else if (sel == 1)
			val = lewql_pkg::Q16_ONE;
		else if (sel == 2)
			val = lewql_pkg::FRAC_W'($urandom_range(65537, 131071));
		else
			val = lewql_pkg::FRAC_W'($urandom_range(0, 32768));
		write_reg(lewql_pkg::REG_HYST, val);
		sel = $urandom_range(0, 19);
		if (sel == 0)
			cnt = 0;
		else if (sel == 1)
			cnt = $urandom_range(5, 7);
		else
			cnt = $urandom_range(1, 4);
		val = lewql_pkg::FRAC_W'(cnt);
		if ($urandom_range(0, 4) == 0)
			val[lewql_pkg::FRAC_W-1:lewql_pkg::LEVEL_W] =
				(lewql_pkg::FRAC_W-lewql_pkg::LEVEL_W)'($urandom_range(0, 16383));
		write_reg(lewql_pkg::REG_THR_COUNT, val);
	endtask

	task automatic test_adaptation_off();
		send_loss(17'h1FFFF);
		send_loss(17'd30000);
	endtask

	task automatic test_first_sample_and_limits();
		write_reg(lewql_pkg::REG_THR_0, 17'd10000);
		write_reg(lewql_pkg::REG_THR_1, 17'd20000);
		write_reg(lewql_pkg::REG_THR_2, 17'd40000);
		write_reg(lewql_pkg::REG_THR_3, 17'd60000);
		write_reg(lewql_pkg::REG_THR_COUNT, 17'd4);
		send_loss(17'h1FFFF);
		send_loss(17'd0);
		send_loss(lewql_pkg::Q16_ONE);
		send_loss(17'd1);
	endtask

	task automatic test_ladder_walk();
		write_reg(lewql_pkg::REG_WEIGHT, lewql_pkg::Q16_ONE);
		write_reg(lewql_pkg::REG_HYST, 17'd16384);
		send_loss(17'd10000);
		send_loss(17'd10001);
		send_loss(17'd20001);
		send_loss(17'd40001);
		send_loss(17'd60001);
		send_loss(17'd50000);
		send_loss(17'd44999);
		send_loss(17'd0);
	endtask

	task automatic test_count_changes();
		write_reg(lewql_pkg::REG_THR_COUNT, 17'd7);
		send_loss(lewql_pkg::Q16_ONE);
		write_reg(lewql_pkg::REG_THR_COUNT, 17'd2);
		send_loss(lewql_pkg::Q16_ONE);
		write_reg(lewql_pkg::REG_THR_COUNT, 17'd1);
		send_loss(17'd5000);
	endtask

	task automatic test_unordered_thresholds();
		write_reg(lewql_pkg::REG_THR_COUNT, 17'd4);
		write_reg(lewql_pkg::REG_HYST, 17'd0);
		write_reg(lewql_pkg::REG_THR_0, 17'd50000);
		write_reg(lewql_pkg::REG_THR_1, 17'd0);
		write_reg(lewql_pkg::REG_THR_2, 17'd98304);
		write_reg(lewql_pkg::REG_THR_3, 17'd10);
		send_loss(17'd30000);
		send_loss(17'd60000);
		send_loss(17'd5);
	endtask

	task automatic test_register_limits();
		write_reg(lewql_pkg::REG_THR_3, 17'h1FFFF);
		write_reg(lewql_pkg::REG_WEIGHT, 17'd0);
		send_loss(lewql_pkg::Q16_ONE);
		write_reg(lewql_pkg::REG_WEIGHT, 17'h1FFFF);
		send_loss(17'd12345);
		write_reg(lewql_pkg::REG_HYST, lewql_pkg::Q16_ONE);
		send_loss(lewql_pkg::Q16_ONE);
		send_loss(17'd0);
		write_reg(lewql_pkg::REG_HYST, 17'h1FFFF);
		send_loss(17'd1);
	endtask

	task automatic test_unknown_register();
		write_reg(REG_UNUSED, 17'd0);
		send_loss(17'd40000);
	endtask

	task automatic test_random_traffic();
		int unsigned n;
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 0) begin
				src_idle_pct = 12;
				sink_stall_pct = 76;
			end else if (ph == 1) begin
				src_idle_pct = 76;
				sink_stall_pct = 12;
			end else begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			for (int c = 0; c < 8; c++) begin
				pick_settings();
				n = $urandom_range(55, 85);
				repeat (n / 2)
					send_loss(pick_loss());
				wait_for_results();
				repeat (n - n / 2)
					send_loss(pick_loss());
			end
		end
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < sink_stall_pct);

	always @(negedge clk) begin : result_check
		ladder_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_ladder.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: level %0d loss %0d",
						requested_level, smoothed_loss);
			end else begin
				want = expected_ladder[0];
				expected_ladder.delete(0);
				if (requested_level !== want.level || smoothed_loss !== want.loss) begin
					mismatches++;
					if (mismatches <= 10)
						$display("expected level %0d loss %0d, got level %0d loss %0d",
							want.level, want.loss, requested_level, smoothed_loss);
				end
			end
		end
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		loss_fraction = '0;
		out_stall = 1'b0;
		thr_count_reg = '0;
		blend_weight = lewql_pkg::WEIGHT_RST;
		hyst_band = '0;
		for (int i = 0; i < 4; i++)
			ladder_thr[i] = lewql_pkg::Q16_ONE;
		ewma_q16 = '0;
		ewma_seeded = 1'b0;
		ladder_level = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_adaptation_off();
		test_first_sample_and_limits();
		test_ladder_walk();
		test_count_changes();
		test_unordered_thresholds();
		test_register_limits();
		test_unknown_register();
		test_random_traffic();

		wait_for_results();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
